// ----- design/ptwt_pkg.sv -----
package ptwt_pkg;

  // Command codes on in_cmd
  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_TRANSLATE = 2'd1,
    CMD_ATTR      = 2'd2
  } cmd_t;

  // Configuration register indexes
  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_KBASE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_t;

  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned IDX_BITS   = 9;

  localparam logic [63:0] OFFS_MASK = 64'h0000_0000_0000_0fff;
  localparam logic [63:0] NEXT_MASK = 64'h7fff_ffff_ffff_f000;

endpackage

// ----- design/page_table_walk_translate.sv -----
// Page table walker with an internal table memory of MEM_WORDS 64-bit words.
// Input channel: a transaction is taken at a rising edge with start high and
// busy low. in_cmd selects a table word write, a translate or an attribute
// read; in_addr is a physical byte address for writes and a virtual address
// otherwise. Config port: cfg_we/cfg_index/cfg_data write root_table_addr
// (index 0) or kernel_base (index 1) at once; write it only while idle.
// Result channel: one result per transaction, held on the out_ ports for one
// cycle with out_valid high. The receiver cannot stall; none is needed.
// Writes, cmd 3 and kernel-region translates answer in the cycle after
// acceptance. A walk reads one table level per cycle through the single
// registered memory read port and one shared index adder; busy drops in
// the same cycle as the walk result shows, so a new transaction can
// follow. An empty upper-level entry ends the walk early with out_fault set.
// Reset: a clearing pass zeroes the table memory, one word a cycle, over all
// MEM_WORDS words; busy stays high during it, config writes still land.
// MEM_WORDS is a power of two: addresses wrap on the word index bits.
module page_table_walk_translate #(
  parameter int unsigned MEM_WORDS = 4096,
  parameter int unsigned LEVELS    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_addr,
  input  logic [63:0] in_data,
  // config port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // result channel
  output logic        out_valid,
  output logic [63:0] out_phys_frame,
  output logic        out_present,
  output logic        out_writable,
  output logic        out_user_access,
  output logic        out_no_execute,
  output logic        out_fault
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned LW = $clog2(LEVELS + 1);
  localparam int unsigned VW = ptwt_pkg::IDX_BITS * LEVELS;
  localparam int unsigned TOP_LSB =
    ptwt_pkg::PAGE_SHIFT + ptwt_pkg::IDX_BITS * (LEVELS - 1);

  // table memory
  logic [63:0] mem_q [MEM_WORDS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rdata_r;

  // control
  ptwt_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [LW-1:0]    lvl_r, lvl_nxt;      // levels still to read, incl. current
  logic [VW-1:0]    vpn_r, vpn_nxt;      // index of the next level to read on top
  logic             attr_r, attr_nxt;

  // config registers
  logic [63:0] root_r, kbase_r;

  // result registers
  logic        ov_r, ov_nxt;
  logic [63:0] phys_r, phys_nxt;
  logic [3:0]  flags_r, flags_nxt;       // {nx, user, writable, present}
  logic        fault_r, fault_nxt;

  // shared index adder: table word base + 9-bit level index
  logic [AW-1:0]                   add_a;
  logic [ptwt_pkg::IDX_BITS-1:0]   add_b;
  logic [63:0]                     root_m, next_m;
  logic                            accept;

  assign accept  = start && !busy;
  assign busy    = (state_r != ptwt_pkg::ST_IDLE);
  assign root_m  = root_r & ~ptwt_pkg::OFFS_MASK;
  assign next_m  = rdata_r & ptwt_pkg::NEXT_MASK;
  assign rd_addr = add_a + AW'(add_b);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= '0;
      kbase_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptwt_pkg::CFG_ROOT:  root_r  <= cfg_data;
        ptwt_pkg::CFG_KBASE: kbase_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptwt_pkg::ST_CLEAR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r   <= lvl_nxt;
    vpn_r   <= vpn_nxt;
    attr_r  <= attr_nxt;
    phys_r  <= phys_nxt;
    flags_r <= flags_nxt;
    fault_r <= fault_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    lvl_nxt   = lvl_r;
    vpn_nxt   = vpn_r;
    attr_nxt  = attr_r;
    ov_nxt    = 1'b0;
    phys_nxt  = phys_r;
    flags_nxt = flags_r;
    fault_nxt = fault_r;
    mem_we    = 1'b0;
    mem_waddr = in_addr[AW+2:3];
    mem_wdata = in_data;
    rd_en     = 1'b0;
    add_a     = root_m[AW+2:3];
    add_b     = in_addr[TOP_LSB +: ptwt_pkg::IDX_BITS];

    unique case (state_r)
      ptwt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        if (clr_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = ptwt_pkg::ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      ptwt_pkg::ST_IDLE: begin
        if (accept) begin
          // default result: all fields zero
          phys_nxt  = '0;
          flags_nxt = '0;
          fault_nxt = 1'b0;
          lvl_nxt   = LW'(LEVELS);
          vpn_nxt   = {in_addr[ptwt_pkg::PAGE_SHIFT +: VW - ptwt_pkg::IDX_BITS],
                       {ptwt_pkg::IDX_BITS{1'b0}}};
          unique case (in_cmd)
            ptwt_pkg::CMD_WRITE: begin
              mem_we = 1'b1;
              ov_nxt = 1'b1;
            end
            ptwt_pkg::CMD_TRANSLATE: begin
              attr_nxt = 1'b0;
              if (in_addr >= kbase_r) begin
                phys_nxt = in_addr & ~kbase_r;
                ov_nxt   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ptwt_pkg::ST_WALK;
              end
            end
            ptwt_pkg::CMD_ATTR: begin
              attr_nxt  = 1'b1;
              rd_en     = 1'b1;
              state_nxt = ptwt_pkg::ST_WALK;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      ptwt_pkg::ST_WALK: begin
        add_a = next_m[AW+2:3];
        add_b = vpn_r[VW-1 -: ptwt_pkg::IDX_BITS];
        if (lvl_r == LW'(1)) begin
          // final entry: an empty one is reported as is
          ov_nxt    = 1'b1;
          phys_nxt  = rdata_r & ~ptwt_pkg::OFFS_MASK;
          flags_nxt = attr_r ? {rdata_r[63], rdata_r[2:0]} : 4'b0000;
          state_nxt = ptwt_pkg::ST_IDLE;
        end else if (rdata_r == '0) begin
          ov_nxt    = 1'b1;
          fault_nxt = 1'b1;
          state_nxt = ptwt_pkg::ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          lvl_nxt = lvl_r - LW'(1);
          vpn_nxt = {vpn_r[VW-ptwt_pkg::IDX_BITS-1:0], {ptwt_pkg::IDX_BITS{1'b0}}};
        end
      end

      default: begin
        state_nxt = ptwt_pkg::ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  assign out_valid       = ov_r;
  assign out_phys_frame  = phys_r;
  assign out_present     = flags_r[0];
  assign out_writable    = flags_r[1];
  assign out_user_access = flags_r[2];
  assign out_no_execute  = flags_r[3];
  assign out_fault       = fault_r;

  // write transactions answer next cycle with an all-zero result
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == ptwt_pkg::CMD_WRITE)
    |=> out_valid && (out_phys_frame == '0) && !out_fault)
    else $error("write transaction result wrong");

  // kernel region translate bypasses the walk
  a_kernel_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == ptwt_pkg::CMD_TRANSLATE) && (in_addr >= kbase_r)
    |=> out_valid && (out_phys_frame == ($past(in_addr) & ~$past(kbase_r))))
    else $error("kernel region translate wrong");

  // a fault result carries nothing else
  a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault
    |-> (out_phys_frame == '0) && !out_present && !out_writable
        && !out_user_access && !out_no_execute)
    else $error("fault result not clean");

  // last level always produces a result and frees the block
  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptwt_pkg::ST_WALK) && (lvl_r == LW'(1))
    |=> out_valid && !busy)
    else $error("walk did not finish");

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the instance under test (defaults of the block)
  localparam int unsigned TB_MEM_WORDS = 4096;
  localparam int unsigned TB_LEVELS    = 4;
  localparam int unsigned WIDX         = $clog2(TB_MEM_WORDS);

  // cmd 3 has no package name; the block answers it with an all-zero result
  localparam logic [1:0] CMD_RSVD = 2'd3;

  // Run limit: clearing pass plus ~1300 transactions, each at worst a full walk
  // stretched by a 57% sender gap rate, taken many times over
  localparam int unsigned CYCLE_LIMIT = 500_000;
  // Cycles to linger after the last result before the verdict
  localparam int unsigned TAIL_CYCLES = 4 * (TB_LEVELS + 1);

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] addr;
    logic [63:0] data;
  } txn_t;

  typedef struct packed {
    logic [63:0] phys_frame;
    logic        present;
    logic        writable;
    logic        user_access;
    logic        no_execute;
    logic        fault;
  } pte_result_t;

  // DUT ports; every input has a known value from time zero
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd    = '0;
  logic [63:0] in_addr   = '0;
  logic [63:0] in_data   = '0;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_data  = '0;
  logic        out_valid;
  logic [63:0] out_phys_frame;
  logic        out_present;
  logic        out_writable;
  logic        out_user_access;
  logic        out_no_execute;
  logic        out_fault;

  // Shadow copy of the walker: table memory and both config registers
  logic [63:0] shadow_mem [TB_MEM_WORDS] = '{default: '0};
  logic [63:0] shadow_root  = '0;
  logic [63:0] shadow_kbase = '0;

  txn_t        txn_pending [$];  // transactions waiting to be taken by the DUT
  pte_result_t frames_due  [$];  // predicted results, oldest first

  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count     = 0;
  int unsigned mismatches      = 0;
  int unsigned n_writes        = 0;
  int unsigned n_kernel        = 0;
  int unsigned n_walks         = 0;
  int unsigned n_faults        = 0;
  int unsigned n_attr          = 0;
  int unsigned n_rsvd          = 0;

  // Root address the stimulus builds its tables under (tracks config writes)
  logic [63:0] cur_root = '0;

  page_table_walk_translate #(
    .MEM_WORDS(TB_MEM_WORDS),
    .LEVELS   (TB_LEVELS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_addr        (in_addr),
    .in_data        (in_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_phys_frame (out_phys_frame),
    .out_present    (out_present),
    .out_writable   (out_writable),
    .out_user_access(out_user_access),
    .out_no_execute (out_no_execute),
    .out_fault      (out_fault)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Table word at byte base + idx words; the word index wraps to the memory
  function automatic logic [63:0] table_word(logic [63:0] byte_base, logic [8:0] idx);
    logic [63:0] w;
    w = (byte_base >> 3) + 64'(idx);
    return shadow_mem[w[WIDX-1:0]];
  endfunction

  // Walks all levels for va; returns 0 when an upper-level entry is empty
  function automatic logic walk_tables(logic [63:0] va, output logic [63:0] leaf);
    logic [63:0] base;
    logic [63:0] e;
    int unsigned lvl;
    int unsigned sh;
    base = shadow_root & ~ptwt_pkg::OFFS_MASK;
    leaf = '0;
    for (lvl = TB_LEVELS; lvl > 1; lvl--) begin
      sh = (lvl - 1) * ptwt_pkg::IDX_BITS + ptwt_pkg::PAGE_SHIFT;
      e = table_word(base, va[sh +: 9]);
      if (e == '0) return 1'b0;
      base = e & ptwt_pkg::NEXT_MASK;
    end
    leaf = table_word(base, va[ptwt_pkg::PAGE_SHIFT +: 9]);
    return 1'b1;
  endfunction

  // Expected result of one transaction; a write also updates the shadow memory
  function automatic pte_result_t predict_walk_result(txn_t t);
    pte_result_t r;
    logic [63:0] leaf;
    r = '0;
    case (t.cmd)
      ptwt_pkg::CMD_WRITE: begin
        shadow_mem[t.addr[WIDX+2:3]] = t.data;
        n_writes++;
      end
      ptwt_pkg::CMD_TRANSLATE: begin
        if (t.addr >= shadow_kbase) begin
          // direct-mapped kernel region: strip the base bits
          r.phys_frame = t.addr & ~shadow_kbase;
          n_kernel++;
        end else if (walk_tables(t.addr, leaf)) begin
          r.phys_frame = leaf & ~ptwt_pkg::OFFS_MASK;
          n_walks++;
        end else begin
          r.fault = 1'b1;
          n_faults++;
        end
      end
      ptwt_pkg::CMD_ATTR: begin
        n_attr++;
        if (walk_tables(t.addr, leaf)) begin
          r.phys_frame  = leaf & ~ptwt_pkg::OFFS_MASK;
          r.present     = leaf[0];
          r.writable    = leaf[1];
          r.user_access = leaf[2];
          r.no_execute  = leaf[63];
          n_walks++;
        end else begin
          r.fault = 1'b1;
          n_faults++;
        end
      end
      default: n_rsvd++;  // reserved command: all-zero result
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch on %s at cycle %0d: got %h, expected %h",
             what, cycle_count, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: new values at the falling edge, one NBA per signal per step.
  // The front of txn_pending is the transaction on the ports while start
  // is high; it leaves the queue at the edge that accepts it.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || txn_pending.size() == 0 ||
        $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
    end else begin
      start   <= 1'b1;
      in_cmd  <= txn_pending[0].cmd;
      in_addr <= txn_pending[0].addr;
      in_data <= txn_pending[0].data;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: samples pre-edge values at the rising edge. Config writes land
  // in the shadow first, then the result is checked, then any transaction
  // taken at this edge is predicted.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor_blk
    pte_result_t want;
    txn_t        taken;
    if (rst_n) begin
      if (cfg_we) begin
        if (cfg_index == ptwt_pkg::CFG_ROOT) shadow_root = cfg_data;
        else shadow_kbase = cfg_data;
      end
      if (out_valid) begin
        if (frames_due.size() == 0) begin
          report_mismatch("result with none outstanding", out_phys_frame, '0);
        end else begin
          want = frames_due.pop_front();
          if (out_phys_frame !== want.phys_frame)
            report_mismatch("phys_frame", out_phys_frame, want.phys_frame);
          if (out_present !== want.present)
            report_mismatch("present", 64'(out_present), 64'(want.present));
          if (out_writable !== want.writable)
            report_mismatch("writable", 64'(out_writable), 64'(want.writable));
          if (out_user_access !== want.user_access)
            report_mismatch("user_access", 64'(out_user_access), 64'(want.user_access));
          if (out_no_execute !== want.no_execute)
            report_mismatch("no_execute", 64'(out_no_execute), 64'(want.no_execute));
          if (out_fault !== want.fault)
            report_mismatch("fault", 64'(out_fault), 64'(want.fault));
        end
      end
      if (start && !busy) begin
        taken = txn_pending.pop_front();
        frames_due.push_back(predict_walk_result(taken));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results outstanding",
               cycle_count, frames_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic enqueue_txn(logic [1:0] cmd, logic [63:0] addr, logic [63:0] data);
    txn_t t;
    t.cmd  = cmd;
    t.addr = addr;
    t.data = data;
    txn_pending.push_back(t);
  endtask

  // Returns once nothing is queued and every predicted result has arrived;
  // the block is idle then, since each transaction yields exactly one result
  task automatic wait_drained();
    while (txn_pending.size() != 0 || frames_due.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(logic [63:0] root, logic [63:0] kbase);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ptwt_pkg::CFG_ROOT;
    cfg_data  <= root;
    @(negedge clk);
    cfg_index <= ptwt_pkg::CFG_KBASE;
    cfg_data  <= kbase;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_root = root;
  endtask

  // Mostly well-formed mappings: write the four entries for a random virtual
  // address (tables picked among the 8 that fit in memory, so mappings share
  // tables), then probe it. The rest is random probes, random writes and
  // reserved commands.
  task automatic run_random_phase(int unsigned n_items);
    int unsigned count;
    int unsigned pick;
    int unsigned lvl;
    int unsigned n_probe;
    logic [63:0] va;
    logic [63:0] wa;
    logic [63:0] wd;
    logic [63:0] pa;
    logic [2:0]  tbl [TB_LEVELS];
    count = 0;
    while (count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        va = {$urandom, $urandom};
        tbl[0] = cur_root[14:12];
        for (lvl = 1; lvl < TB_LEVELS; lvl++) tbl[lvl] = 3'($urandom_range(0, 7));
        for (lvl = 0; lvl < TB_LEVELS; lvl++) begin
          wa = {$urandom, $urandom};
          wa[14:3] = {tbl[lvl], va[39 - 9 * lvl +: 9]};
          wd = {$urandom, $urandom};
          if (lvl < TB_LEVELS - 1) begin
            wd[14:12] = tbl[lvl + 1];
          end else if ($urandom_range(0, 9) == 0) begin
            wd = '0;  // empty final entry
          end
          // a skipped link leaves whatever the table held before
          if ($urandom_range(0, 99) >= 8) begin
            enqueue_txn(ptwt_pkg::CMD_WRITE, wa, wd);
            count++;
          end
        end
        n_probe = $urandom_range(1, 3);
        repeat (n_probe) begin
          pa = va;
          pa[11:0] = 12'($urandom);
          if ($urandom_range(0, 4) == 0) pa[$urandom_range(12, 47)] ^= 1'b1;
          enqueue_txn($urandom_range(0, 1) ? ptwt_pkg::CMD_TRANSLATE : ptwt_pkg::CMD_ATTR,
                      pa, {$urandom, $urandom});
          count++;
        end
      end else if (pick < 85) begin
        enqueue_txn($urandom_range(0, 1) ? ptwt_pkg::CMD_TRANSLATE : ptwt_pkg::CMD_ATTR,
                    {$urandom, $urandom}, {$urandom, $urandom});
        count++;
      end else if (pick < 95) begin
        enqueue_txn(ptwt_pkg::CMD_WRITE, {$urandom, $urandom}, {$urandom, $urandom});
        count++;
      end else begin
        enqueue_txn(CMD_RSVD, {$urandom, $urandom}, {$urandom, $urandom});
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Config writes land during the clearing pass. Root in table 1 with its
    // offset bits set (they must be ignored); kernel base at the top, so
    // nearly every translate walks.
    sender_idle_pct = 34;
    set_config(64'h0000_0000_0000_1fff, 64'hffff_ffff_ffff_ffff);

    // Directed part
    enqueue_txn(CMD_RSVD, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    // kernel region edge
    enqueue_txn(ptwt_pkg::CMD_TRANSLATE, 64'hffff_ffff_ffff_ffff, '0);
    // empty root table: fault
    enqueue_txn(ptwt_pkg::CMD_TRANSLATE, '0, '0);
    enqueue_txn(ptwt_pkg::CMD_ATTR, '0, '0);
    // Map va 0x0000_ffff_ffff_ffff (all indexes 511) through tables 1->2->3->4;
    // upper entries carry junk in bit 63 and the offset bits
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'h1ff8, 64'h8000_0000_0000_2fff);
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'h2ff8, 64'h0000_0000_0000_3007);
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'h3ff8, 64'h0000_0000_0000_4001);
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'h4ff8, 64'hffff_ffff_ffff_ffff);
    enqueue_txn(ptwt_pkg::CMD_TRANSLATE, 64'h0000_ffff_ffff_ffff, '0);
    enqueue_txn(ptwt_pkg::CMD_ATTR, 64'h0000_ffff_ffff_ffff, '0);
    // Same path, leaf index 0: empty final entry, no fault
    enqueue_txn(ptwt_pkg::CMD_ATTR, 64'h0000_ffff_ffe0_0000, '0);
    // High address bits wrap onto table 4 word 0
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'hffff_ffff_ffff_4000, 64'h0000_0000_0000_0ffe);
    enqueue_txn(ptwt_pkg::CMD_ATTR, 64'h0000_ffff_ffe0_0000, '0);
    // PD index 0 is empty: walk stops at an upper level
    enqueue_txn(ptwt_pkg::CMD_TRANSLATE, 64'h0000_ffff_c000_0000, '0);
    // Nonzero PD entry whose masked address is 0: next table is table 0
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'h3000, 64'h8000_0000_0000_0000);
    enqueue_txn(ptwt_pkg::CMD_WRITE, '0, 64'h8000_0000_0000_0001);
    enqueue_txn(ptwt_pkg::CMD_ATTR, 64'h0000_ffff_c000_0000, '0);
    enqueue_txn(CMD_RSVD, '0, '0);
    enqueue_txn(ptwt_pkg::CMD_WRITE, '0, '0);
    enqueue_txn(ptwt_pkg::CMD_ATTR, 64'h0000_ffff_c000_0000, '0);
    enqueue_txn(ptwt_pkg::CMD_WRITE, 64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555);
    wait_drained();

    // Random phases: each boundary drains fully before the config changes
    set_config(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    run_random_phase(250);
    set_config({$urandom, $urandom}, 64'h8000_0000_0000_0000);
    run_random_phase(250);

    sender_idle_pct = 57;
    set_config('0, '0);  // every translate takes the kernel path
    run_random_phase(250);
    set_config({$urandom, $urandom}, {$urandom, $urandom});
    run_random_phase(250);

    sender_idle_pct = 0;
    set_config({$urandom, $urandom}, 64'hffff_8000_0000_0000);
    run_random_phase(250);

    // Catch any stray result after the last expected one
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("tb: %0d table writes, %0d attribute reads, %0d reserved commands",
             n_writes, n_attr, n_rsvd);
    $display("tb: %0d full walks, %0d walk faults, %0d kernel-region translates",
             n_walks, n_faults, n_kernel);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ptwt_pkg.sv
design/page_table_walk_translate.sv
sim/tb.sv
